>>> rtl/core/mtct_pkg.sv
// Shared types and constants for the multitouch centroid tracker.
// Holds table geometry, event and status codes, the entry layout and
// the request/response structs of the mean divider. No dependencies.
package mtct_pkg;

    // Table geometry
    localparam int MAX_CONTACTS = 16;
    localparam int IDX_W        = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CNT_W        = $clog2(MAX_CONTACTS + 1);
    localparam int ID_W         = 16;
    localparam int POS_W        = 16;
    localparam int SUM_W        = POS_W + CNT_W;
    localparam int DIV_STEP_W   = $clog2(SUM_W + 1);

    // Event kinds
    localparam logic [1:0] OP_DOWN   = 2'd0;
    localparam logic [1:0] OP_UP     = 2'd1;
    localparam logic [1:0] OP_MOTION = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_UPD,
        S_DIV,
        S_DIVW,
        S_OUT
    } t_state;

    // One table entry: recency rank (0 = newest), id and position
    typedef struct packed {
        logic [IDX_W-1:0] age;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_entry;

    // Mean divider request and response
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [CNT_W-1:0] count;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] mean_x;
        logic [POS_W-1:0] mean_y;
    } t_div_rsp;

endpackage

>>> rtl/core/multitouch_centroid_tracker_unit.sv
// Multitouch centroid tracker, top level. Uses mtct_pkg, mtct_entry_ram, mtct_divider.
// One transaction at a time: a table search, a rewrite pass when the table changes, a
// divide issue, a two-coordinate divide when contacts remain, then a load of the output
// register. The next input is taken only once the result has been loaded.
// Reset clears valid bits, count and sums at once; entry memory is not cleared.
module multitouch_centroid_tracker_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_op,
    input  logic [mtct_pkg::ID_W-1:0]  i_contact_id,
    input  logic [mtct_pkg::POS_W-1:0] i_pos_x,
    input  logic [mtct_pkg::POS_W-1:0] i_pos_y,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_warp,
    output logic [mtct_pkg::POS_W-1:0] o_center_x,
    output logic [mtct_pkg::POS_W-1:0] o_center_y,
    output logic [1:0]                 o_status
);
    import mtct_pkg::*;

    localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(MAX_CONTACTS);

    // Controller state
    t_state r_state, n_state;

    // Table control state
    logic [MAX_CONTACTS-1:0] r_used;
    logic [CNT_W-1:0]        r_count;
    logic [SUM_W-1:0]        r_sum_x;
    logic [SUM_W-1:0]        r_sum_y;

    // Walk pointer and read pipeline
    logic [CNT_W-1:0]        r_addr;
    logic                    r_dat_vld;
    logic [IDX_W-1:0]        r_dat_idx;

    // Current transaction
    logic [1:0]              r_op;
    logic [ID_W-1:0]         r_id;
    logic [POS_W-1:0]        r_px;
    logic [POS_W-1:0]        r_py;
    logic                    r_hit;
    logic [IDX_W-1:0]        r_slot;
    logic [IDX_W-1:0]        r_best_age;
    logic [POS_W-1:0]        r_old_x;
    logic [POS_W-1:0]        r_old_y;
    logic [1:0]              r_status;
    logic [POS_W-1:0]        r_mean_x;
    logic [POS_W-1:0]        r_mean_y;

    // Output register
    logic                    r_out_valid;
    logic                    r_warp;
    logic [POS_W-1:0]        r_center_x;
    logic [POS_W-1:0]        r_center_y;
    logic [1:0]              r_out_status;

    // Memory and divider connections
    logic                    ram_we;
    t_entry                  ram_wdata;
    t_entry                  ram_rdata;
    t_div_req                div_req;
    t_div_rsp                div_rsp;

    // Decode
    logic                    accept;
    logic                    walk_end;
    logic                    full;
    logic [IDX_W-1:0]        free_slot;
    logic                    do_down;
    logic                    do_hit;
    logic [1:0]              evt_status;
    logic                    match;
    logic                    is_slot;
    logic                    load_out;

    // Lowest-numbered free slot
    function automatic logic [IDX_W-1:0] first_free(input logic [MAX_CONTACTS-1:0] used);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_CONTACTS - 1; i >= 0; i--) begin
            if (!used[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    mtct_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_dat_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    mtct_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Event decode at the end of the search
    always_comb begin
        accept    = i_in_valid && (r_state == S_IDLE);
        walk_end  = (r_addr == LAST_ADDR) && !r_dat_vld;
        full      = &r_used;
        free_slot = first_free(r_used);
        do_down   = (r_op == OP_DOWN) && !full;
        do_hit    = ((r_op == OP_UP) || (r_op == OP_MOTION)) && r_hit;
        if ((r_op == OP_DOWN) && full) begin
            evt_status = ST_FULL;
        end else if (((r_op == OP_UP) || (r_op == OP_MOTION)) && !r_hit) begin
            evt_status = ST_NOT_FOUND;
        end else begin
            evt_status = ST_OK;
        end
        match    = r_used[r_dat_idx] && (ram_rdata.id == r_id)
                   && (!r_hit || (ram_rdata.age < r_best_age));
        is_slot  = (r_dat_idx == r_slot);
        load_out = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    end

    // Rewrite pass: shift ranks and place the new or moved entry
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = ram_rdata;
        if ((r_state == S_UPD) && r_dat_vld) begin
            case (r_op)
                OP_DOWN: begin
                    if (is_slot) begin
                        ram_we    = 1'b1;
                        ram_wdata = '{age: '0, id: r_id, x: r_px, y: r_py};
                    end else if (r_used[r_dat_idx]) begin
                        ram_we        = 1'b1;
                        ram_wdata.age = ram_rdata.age + 1'b1;
                    end
                end
                OP_UP: begin
                    if (r_used[r_dat_idx] && (ram_rdata.age > r_best_age)) begin
                        ram_we        = 1'b1;
                        ram_wdata.age = ram_rdata.age - 1'b1;
                    end
                end
                OP_MOTION: begin
                    if (is_slot) begin
                        ram_we    = 1'b1;
                        ram_wdata = '{age: r_best_age, id: r_id, x: r_px, y: r_py};
                    end
                end
                default: begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    // Divider request
    always_comb begin
        div_req.start = (r_state == S_DIV) && (r_count != '0);
        div_req.sum_x = r_sum_x;
        div_req.sum_y = r_sum_y;
        div_req.count = r_count;
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (walk_end) begin
                    n_state = (do_down || do_hit) ? S_UPD : S_DIV;
                end
            end
            S_UPD: begin
                if (walk_end) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_state = (r_count != '0) ? S_DIVW : S_OUT;
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Walk pointer: issue one read a cycle, drain the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_dat_vld <= 1'b0;
        end else if (((r_state == S_SRCH) || (r_state == S_UPD)) && !walk_end) begin
            if (r_addr != LAST_ADDR) begin
                r_addr    <= r_addr + 1'b1;
                r_dat_vld <= 1'b1;
            end else begin
                r_dat_vld <= 1'b0;
            end
        end else begin
            r_addr    <= '0;
            r_dat_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dat_idx <= r_addr[IDX_W-1:0];
    end

    // Table control: valid bits, count and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if ((r_state == S_SRCH) && walk_end) begin
            if (do_down) begin
                r_used[free_slot] <= 1'b1;
                r_count           <= r_count + 1'b1;
                r_sum_x           <= r_sum_x + SUM_W'(r_px);
                r_sum_y           <= r_sum_y + SUM_W'(r_py);
            end else if (do_hit && (r_op == OP_UP)) begin
                r_used[r_slot] <= 1'b0;
                r_count        <= r_count - 1'b1;
                r_sum_x        <= r_sum_x - SUM_W'(r_old_x);
                r_sum_y        <= r_sum_y - SUM_W'(r_old_y);
            end else if (do_hit) begin
                r_sum_x <= r_sum_x + SUM_W'(r_px) - SUM_W'(r_old_x);
                r_sum_y <= r_sum_y + SUM_W'(r_py) - SUM_W'(r_old_y);
            end
        end
    end

    // Transaction capture, newest-match search and mean hold
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_id  <= i_contact_id;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_hit <= 1'b0;
        end
        if ((r_state == S_SRCH) && r_dat_vld && match) begin
            r_hit      <= 1'b1;
            r_slot     <= r_dat_idx;
            r_best_age <= ram_rdata.age;
            r_old_x    <= ram_rdata.x;
            r_old_y    <= ram_rdata.y;
        end
        if ((r_state == S_SRCH) && walk_end) begin
            r_status <= evt_status;
            if (do_down) begin
                r_slot <= free_slot;
            end
        end
        if ((r_state == S_DIV) && (r_count == '0)) begin
            r_mean_x <= '0;
            r_mean_y <= '0;
        end else if ((r_state == S_DIVW) && div_rsp.done) begin
            r_mean_x <= div_rsp.mean_x;
            r_mean_y <= div_rsp.mean_y;
        end
    end

    // Output register: load the result, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_warp       <= (r_count != '0);
            r_center_x   <= r_mean_x;
            r_center_y   <= r_mean_y;
            r_out_status <= r_status;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_warp      = r_warp;
    assign o_center_x  = r_center_x;
    assign o_center_y  = r_center_y;
    assign o_status    = r_out_status;

endmodule

>>> rtl/core/mtct_entry_ram.sv
// Contact table storage: one write port, one read port, registered read.
// Depends on mtct_pkg for the entry layout and table depth.
module mtct_entry_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [mtct_pkg::IDX_W-1:0]   i_waddr,
    input  mtct_pkg::t_entry             i_wdata,
    input  logic [mtct_pkg::IDX_W-1:0]   i_raddr,
    output mtct_pkg::t_entry             o_rdata
);
    import mtct_pkg::*;

    t_entry r_mem [MAX_CONTACTS];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mtct_divider.sv
// Restoring divider for the centroid: divides both coordinate sums by the
// contact count, one quotient bit per cycle. Depends on mtct_pkg.
module mtct_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mtct_pkg::t_div_req i_req,
    output mtct_pkg::t_div_rsp o_rsp
);
    import mtct_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [CNT_W-1:0]      r_div;
    logic [SUM_W-1:0]      r_qx;
    logic [SUM_W-1:0]      r_qy;
    logic [CNT_W-1:0]      r_rx;
    logic [CNT_W-1:0]      r_ry;

    logic [CNT_W:0]        trial_x;
    logic [CNT_W:0]        trial_y;
    logic [CNT_W:0]        rem_x;
    logic [CNT_W:0]        rem_y;
    logic                  ge_x;
    logic                  ge_y;

    // Shift the next dividend bit into the partial remainder and try a subtract
    always_comb begin
        trial_x = {r_rx, r_qx[SUM_W-1]};
        trial_y = {r_ry, r_qy[SUM_W-1]};
        ge_x    = trial_x >= {1'b0, r_div};
        ge_y    = trial_y >= {1'b0, r_div};
        rem_x   = ge_x ? (trial_x - {1'b0, r_div}) : trial_x;
        rem_y   = ge_y ? (trial_y - {1'b0, r_div}) : trial_y;
    end

    // Control: count steps, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DIV_STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.count;
            r_qx  <= i_req.sum_x;
            r_qy  <= i_req.sum_y;
            r_rx  <= '0;
            r_ry  <= '0;
        end else if (r_busy) begin
            r_qx <= {r_qx[SUM_W-2:0], ge_x};
            r_qy <= {r_qy[SUM_W-2:0], ge_y};
            r_rx <= rem_x[CNT_W-1:0];
            r_ry <= rem_y[CNT_W-1:0];
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.mean_x = r_qx[POS_W-1:0];
    assign o_rsp.mean_y = r_qy[POS_W-1:0];

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for multitouch_centroid_tracker_unit.
// Walks a short directed table of touch events, then state-aware random traffic, and checks every
// centroid against the table's expectations or a local table tracker. Depends on mtct_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
    import mtct_pkg::*;

    localparam logic [1:0] OP_IGNORED  = 2'd3;
    localparam int         N_RANDOM    = 2000;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         PRINT_CAP   = 30;

    typedef struct packed {
        logic [1:0]       op;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_touch;

    typedef struct packed {
        logic             warp;
        logic [POS_W-1:0] center_x;
        logic [POS_W-1:0] center_y;
        logic [1:0]       status;
    } t_centroid;

    typedef struct {
        t_touch    ev;
        int        rep;
        bit        typed;
        t_centroid want;
    } t_row;

    logic             i_clk;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_stall;
    logic [1:0]       i_op         = OP_DOWN;
    logic [ID_W-1:0]  i_contact_id = '0;
    logic [POS_W-1:0] i_pos_x      = '0;
    logic [POS_W-1:0] i_pos_y      = '0;
    logic             o_out_valid;
    logic             i_out_stall  = 1'b0;
    logic             o_warp;
    logic [POS_W-1:0] o_center_x;
    logic [POS_W-1:0] o_center_y;
    logic [1:0]       o_status;

    // Typed expectation travelling with the offered transaction
    bit        cur_typed = 1'b0;
    t_centroid cur_want  = '0;

    // Local copy of the contact table
    logic             tbl_used [MAX_CONTACTS];
    logic [ID_W-1:0]  tbl_id   [MAX_CONTACTS];
    logic [POS_W-1:0] tbl_x    [MAX_CONTACTS];
    logic [POS_W-1:0] tbl_y    [MAX_CONTACTS];
    logic [4:0]       tbl_age  [MAX_CONTACTS];
    int               tbl_count = 0;

    t_centroid centroid_q[$];
    t_row      directed_q[$];

    int  n_errors     = 0;
    int  n_in         = 0;
    int  n_out        = 0;
    int  n_full_drops = 0;
    int  n_unknown    = 0;
    int  n_ignored    = 0;
    int  peak_count   = 0;
    int  cycles       = 0;
    int  burst_left   = 1;
    bit  fill_bias    = 1'b1;
    bit  hold_done    = 1'b0;

    multitouch_centroid_tracker_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_contact_id (i_contact_id),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_warp       (o_warp),
        .o_center_x   (o_center_x),
        .o_center_y   (o_center_y),
        .o_status     (o_status)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Flag one mismatch and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= PRINT_CAP)
            $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    // Newest valid slot holding this id, or -1
    function automatic int newest_slot(logic [ID_W-1:0] id);
        int best;
        best = -1;
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            if (tbl_used[i] && tbl_id[i] == id)
                if (best < 0 || tbl_age[i] < tbl_age[best])
                    best = i;
        end
        return best;
    endfunction

    // Apply one event to the local table and work out the centroid it reports
    function automatic t_centroid track_event(t_touch ev);
        t_centroid   res;
        int          slot;
        logic [31:0] sum_x;
        logic [31:0] sum_y;
        logic [31:0] n;
        res   = '0;
        slot  = -1;
        sum_x = '0;
        sum_y = '0;
        n     = '0;
        res.status = ST_OK;
        case (ev.op)
            OP_DOWN: begin
                for (int i = MAX_CONTACTS - 1; i >= 0; i--)
                    if (!tbl_used[i])
                        slot = i;
                if (slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = 0; i < MAX_CONTACTS; i++)
                        if (tbl_used[i])
                            tbl_age[i] = tbl_age[i] + 5'd1;
                    tbl_used[slot] = 1'b1;
                    tbl_id[slot]   = ev.id;
                    tbl_x[slot]    = ev.x;
                    tbl_y[slot]    = ev.y;
                    tbl_age[slot]  = '0;
                    tbl_count++;
                end
            end
            OP_UP: begin
                slot = newest_slot(ev.id);
                if (slot < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    for (int i = 0; i < MAX_CONTACTS; i++)
                        if (tbl_used[i] && tbl_age[i] > tbl_age[slot])
                            tbl_age[i] = tbl_age[i] - 5'd1;
                    tbl_used[slot] = 1'b0;
                    tbl_count--;
                end
            end
            OP_MOTION: begin
                slot = newest_slot(ev.id);
                if (slot < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    tbl_x[slot] = ev.x;
                    tbl_y[slot] = ev.y;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            if (tbl_used[i]) begin
                sum_x += tbl_x[i];
                sum_y += tbl_y[i];
                n++;
            end
        end
        if (n > 0) begin
            res.warp     = 1'b1;
            res.center_x = POS_W'(sum_x / n);
            res.center_y = POS_W'(sum_y / n);
        end
        return res;
    endfunction

    // Position with extra weight on the extremes
    function automatic logic [POS_W-1:0] pick_pos();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return POS_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Id of a random live contact; caller makes sure the table is not empty
    function automatic logic [ID_W-1:0] live_id();
        int s;
        do
            s = $urandom_range(0, MAX_CONTACTS - 1);
        while (!tbl_used[s]);
        return tbl_id[s];
    endfunction

    // Mostly well-formed gestures on live contacts, some noise
    function automatic t_touch pick_event();
        t_touch ev;
        int     r;
        r     = $urandom_range(0, 99);
        ev.id = ID_W'($urandom_range(0, 16'hFFFF));
        ev.x  = pick_pos();
        ev.y  = pick_pos();
        if (r < 4) begin
            ev.op = OP_IGNORED;
        end else if (r < 12) begin
            ev.op = $urandom_range(0, 1) ? OP_UP : OP_MOTION;
        end else if (tbl_count == 0 || r < (fill_bias ? 60 : 34)) begin
            ev.op = OP_DOWN;
            if (tbl_count > 0 && $urandom_range(0, 4) == 0)
                ev.id = live_id();
        end else if (r < (fill_bias ? 85 : 70)) begin
            ev.op = OP_MOTION;
            ev.id = live_id();
        end else begin
            ev.op = OP_UP;
            ev.id = live_id();
        end
        return ev;
    endfunction

    function automatic void add_row(logic [1:0] op, logic [ID_W-1:0] id, logic [POS_W-1:0] x,
                                    logic [POS_W-1:0] y, int rep, bit typed, logic warp,
                                    logic [POS_W-1:0] cx, logic [POS_W-1:0] cy,
                                    logic [1:0] st);
        t_row row;
        row.ev    = '{op, id, x, y};
        row.rep   = rep;
        row.typed = typed;
        row.want  = '{warp, cx, cy, st};
        directed_q.push_back(row);
    endfunction

    // Offer one transaction from a falling edge, hold it until taken, then pace the burst
    task automatic offer(input t_touch ev, input bit typed, input t_centroid want);
        int gap;
        i_in_valid   <= 1'b1;
        i_op         <= ev.op;
        i_contact_id <= ev.id;
        i_pos_x      <= ev.x;
        i_pos_y      <= ev.y;
        cur_typed    <= typed;
        cur_want     <= want;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
        if (burst_left > 1) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 80);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Check results against the oldest expectation, then record newly taken events
    always @(posedge i_clk) begin : centroid_check
        t_centroid want;
        t_centroid pred;
        t_touch    seen;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                n_out++;
                if (centroid_q.size() == 0) begin
                    report_mismatch("result with no transaction outstanding",
                                    {o_center_x, o_center_y}, '0);
                end else begin
                    want = centroid_q.pop_front();
                    if (o_warp !== want.warp)
                        report_mismatch("warp", o_warp, want.warp);
                    if (o_center_x !== want.center_x)
                        report_mismatch("center_x", o_center_x, want.center_x);
                    if (o_center_y !== want.center_y)
                        report_mismatch("center_y", o_center_y, want.center_y);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                seen = '{i_op, i_contact_id, i_pos_x, i_pos_y};
                pred = track_event(seen);
                centroid_q.push_back(cur_typed ? cur_want : pred);
                n_in++;
                if (pred.status == ST_FULL)
                    n_full_drops++;
                if (pred.status == ST_NOT_FOUND)
                    n_unknown++;
                if (seen.op == OP_IGNORED)
                    n_ignored++;
                if (tbl_count > peak_count)
                    peak_count = tbl_count;
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycles, centroid_q.size());
            $display("multitouch_centroid_tracker_unit test failed");
            $finish;
        end
    end

    // Result-side stall: quiet stretches, random stalls, a fixed duty pattern, one long hold-off
    initial begin : out_stall_gen
        int mode;
        int seg_len;
        int on_len;
        int off_len;
        forever begin
            if (!hold_done && n_in >= 600) begin
                hold_done = 1'b1;
                for (int k = 0; k < 400; k++) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            mode    = $urandom_range(0, 2);
            seg_len = $urandom_range(20, 200);
            on_len  = $urandom_range(1, 6);
            off_len = $urandom_range(1, 6);
            for (int k = 0; k < seg_len; k++) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 2) == 0);
                    default: i_out_stall <= ((k % (on_len + off_len)) < on_len);
                endcase
            end
        end
    end

    // Reset, directed table, random traffic, drain, verdict
    initial begin : stimulus
        t_touch ev;
        int     n_live;
        int     n_sent;
        n_live = 0;
        n_sent = 0;
        foreach (tbl_used[i]) begin
            tbl_used[i] = 1'b0;
            tbl_id[i]   = '0;
            tbl_x[i]    = '0;
            tbl_y[i]    = '0;
            tbl_age[i]  = '0;
        end

        //      op          id        x         y         rep           typed warp cx  cy   status
        add_row(OP_MOTION,  16'h0005, 16'h1234, 16'h5678, 1,            1, 0, 0,         0,
                ST_NOT_FOUND);
        add_row(OP_UP,      16'h0000, 16'h0000, 16'h0000, 1,            1, 0, 0,         0,
                ST_NOT_FOUND);
        add_row(OP_IGNORED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,            1, 0, 0,         0,
                ST_OK);
        add_row(OP_DOWN,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1,            1, 1, 16'hFFFF,
                16'hFFFF, ST_OK);
        add_row(OP_DOWN,    16'h0000, 16'h0000, 16'h0000, 1,            1, 1, 16'h7FFF,
                16'h7FFF, ST_OK);
        // duplicate id: motion and up must hit the newer of the two
        add_row(OP_DOWN,    16'h0000, 16'h3000, 16'h0001, 1,            0, 0, 0, 0, ST_OK);
        add_row(OP_MOTION,  16'h0000, 16'hFFFF, 16'h0000, 1,            0, 0, 0, 0, ST_OK);
        add_row(OP_UP,      16'h0000, 16'h0000, 16'h0000, 1,            0, 0, 0, 0, ST_OK);
        add_row(OP_UP,      16'h0000, 16'hABCD, 16'hDCBA, 1,            1, 1, 16'hFFFF,
                16'hFFFF, ST_OK);
        add_row(OP_IGNORED, 16'h5A5A, 16'h1234, 16'h4321, 1,            1, 1, 16'hFFFF,
                16'hFFFF, ST_OK);
        add_row(OP_UP,      16'hFFFF, 16'h0000, 16'h0000, 1,            1, 0, 0,         0,
                ST_OK);
        // fill the table, then overflow it
        add_row(OP_DOWN,    16'h8001, 16'hFFFF, 16'hFFFF, MAX_CONTACTS, 1, 1, 16'hFFFF,
                16'hFFFF, ST_OK);
        add_row(OP_DOWN,    16'h1234, 16'h0000, 16'h0000, 1,            1, 1, 16'hFFFF,
                16'hFFFF, ST_FULL);
        add_row(OP_UP,      16'h7FFE, 16'h0000, 16'h0000, 1,            1, 1, 16'hFFFF,
                16'hFFFF, ST_NOT_FOUND);
        add_row(OP_MOTION,  16'h8001, 16'h0000, 16'h0000, 1,            0, 0, 0, 0, ST_OK);
        add_row(OP_DOWN,    16'h4321, 16'h0000, 16'h0000, 1,            0, 0, 0, 0, ST_OK);
        // drain every duplicate
        add_row(OP_UP,      16'h8001, 16'h0000, 16'h0000, MAX_CONTACTS, 0, 0, 0, 0, ST_OK);
        add_row(OP_MOTION,  16'h8001, 16'h5555, 16'hAAAA, 1,            1, 0, 0,         0,
                ST_NOT_FOUND);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[r])
            for (int k = 0; k < directed_q[r].rep; k++)
                offer(directed_q[r].ev, directed_q[r].typed, directed_q[r].want);

        // alternate fill-heavy and drain-heavy stretches
        while (n_live < N_RANDOM) begin
            if (n_sent % 150 == 0)
                fill_bias = $urandom_range(0, 1);
            ev = pick_event();
            offer(ev, 1'b0, '0);
            n_sent++;
            if (ev.op != OP_IGNORED)
                n_live++;
        end
        i_in_valid <= 1'b0;

        // drain, then allow for a stray late result
        while (centroid_q.size() != 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);

        $display("Ran %0d events (%0d ignored opcodes) and checked %0d centroids in %0d cycles.",
                 n_in, n_ignored, n_out, cycles);
        $display("Saw %0d table-full drops, %0d unknown-id events, peak of %0d contacts.",
                 n_full_drops, n_unknown, peak_count);
        if (n_errors == 0) begin
            $display("multitouch_centroid_tracker_unit test passed");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("multitouch_centroid_tracker_unit test failed");
        end
        $finish;
    end

endmodule
